[hdl/window_majority_vote_smoother_defines.svh]
// ----------------------------------------------------------------------------
// Window majority vote smoother: assertion macros
// Short forms for the concurrent checks of the smoother, all clocked on the
// rising edge and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MAJORITY_VOTE_SMOOTHER_DEFINES_SVH
`define WINDOW_MAJORITY_VOTE_SMOOTHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMVS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smoother check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define WMVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smoother check failed in the following cycle");

`endif

[hdl/wmvs_pkg.sv]
// ----------------------------------------------------------------------------
// Window majority vote smoother: package
// Widths, class and outcome codes, the command bundle between controller
// and datapath, and the decision classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package wmvs_pkg;

   localparam int WINDOW_LEN  = 6;
   localparam int LABELS      = 4;
   localparam int CLASS_COUNT = LABELS + 2;

   localparam int KIND_W  = 2;
   localparam int LABEL_W = 2;
   localparam int CLASS_W = $clog2(CLASS_COUNT);
   localparam int COUNT_W = $clog2(WINDOW_LEN + 1);
   localparam int OUT_W   = 2;
   localparam int THR_W   = 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam logic [KIND_W-1:0] KIND_LABEL     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNCERTAIN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ANOMALY   = 2'd2;

   localparam class_type CLASS_UNCERTAIN = CLASS_W'(LABELS);
   localparam class_type CLASS_ANOMALY   = CLASS_W'(LABELS + 1);
   localparam class_type CLASS_LAST      = CLASS_W'(CLASS_COUNT - 1);

   localparam logic [OUT_W-1:0] OUTCOME_LABEL     = 2'd0;
   localparam logic [OUT_W-1:0] OUTCOME_UNCERTAIN = 2'd1;
   localparam logic [OUT_W-1:0] OUTCOME_ANOMALY   = 2'd2;

   localparam logic [0:0]       REG_VOTE_THRESHOLD   = 1'b0;
   localparam logic [THR_W-1:0] VOTE_THRESHOLD_RESET = 3'd4;

   typedef struct packed {
      logic      load_item;
      logic      scan;
      class_type scan_class;
      logic      load_out;
   } dp_cmd_type;

   // Maps one decision to its class; meaningless codes count as uncertain.
   function automatic class_type classify(input logic [KIND_W-1:0]  kind,
                                          input logic [LABEL_W-1:0] label);
      class_type cls;
      cls = CLASS_UNCERTAIN;
      if (kind == KIND_LABEL) begin
         if ({1'b0, label} < (LABEL_W+1)'(LABELS)) begin
            cls = CLASS_W'(label);
         end
      end else if (kind == KIND_ANOMALY) begin
         cls = CLASS_ANOMALY;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

[hdl/wmvs_req_if.sv]
// ----------------------------------------------------------------------------
// Window majority vote smoother: decision channel
// Valid/ready channel carrying one classifier decision per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmvs_req_if;
   logic                         valid;
   logic                         ready;
   logic [wmvs_pkg::KIND_W-1:0]  reading_kind;
   logic [wmvs_pkg::LABEL_W-1:0] reading_label;

   modport source (output valid, output reading_kind, output reading_label,
                   input ready);
   modport sink   (input valid, input reading_kind, input reading_label,
                   output ready);
endinterface

`default_nettype wire

[hdl/wmvs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Window majority vote smoother: result channel
// Valid/ready channel carrying one smoothed vote per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmvs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wmvs_pkg::OUT_W-1:0]   outcome;
   logic [wmvs_pkg::LABEL_W-1:0] winning_label;
   logic [wmvs_pkg::COUNT_W-1:0] winning_count;

   modport source (output valid, output outcome, output winning_label,
                   output winning_count, input ready);
   modport sink   (input valid, input outcome, input winning_label,
                   input winning_count, output ready);
endinterface

`default_nettype wire

[hdl/window_majority_vote_smoother.sv]
// ----------------------------------------------------------------------------
// Window majority vote smoother: top level
// Smooths a stream of classifier decisions by a majority vote over the last
// six decisions, with a programmable vote threshold.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req       in          reading_kind, reading_label
//   rsp       out         outcome, winning_label, winning_count
//   csr       in/out      vote_threshold at byte address 0
//
// A decision is taken in the idle step, the six classes are then scanned one
// per cycle and a final step loads the result. The next decision is taken
// while the result still waits for its transfer. Reset is synchronous and
// leaves the window all uncertain with a threshold of four. A stalled result
// holds the controller in its final step until the register is free.
//
`default_nettype none
`include "window_majority_vote_smoother_defines.svh"

module window_majority_vote_smoother (
   input  wire                                 clock,
   input  wire                                 reset,
   wmvs_req_if.sink                            req,
   wmvs_rsp_if.source                          rsp,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [wmvs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire [wmvs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wmvs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   wmvs_pkg::dp_cmd_type         cmd;
   logic [wmvs_pkg::THR_W-1:0]   threshold_ff;
   logic                         csr_write;
   logic                         reg_hit;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == wmvs_pkg::REG_VOTE_THRESHOLD);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= wmvs_pkg::VOTE_THRESHOLD_RESET;
      end else if (csr_write && reg_hit) begin
         threshold_ff <= csr_pwdata[wmvs_pkg::THR_W-1:0];
      end
   end

   assign csr_prdata = reg_hit ? wmvs_pkg::CSR_DATA_W'(threshold_ff) : '0;

   wmvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   wmvs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .reading_kind   (req.reading_kind),
      .reading_label  (req.reading_label),
      .vote_threshold (threshold_ff),
      .outcome        (rsp.outcome),
      .winning_label  (rsp.winning_label),
      .winning_count  (rsp.winning_count)
   );

   // One decision at a time: after a transfer in, the input side is closed.
   `WMVS_ASSERT_NEXT(a_busy_after_take, clock, reset, req.valid && req.ready, !req.ready)
   // A taken result is not shown again unless a new one was loaded.
   `WMVS_ASSERT_NEXT(a_no_repeat, clock, reset, rsp.valid && rsp.ready && !cmd.load_out, !rsp.valid)
   // Only a confirmed label carries a label index.
   `WMVS_ASSERT_SAME(a_label_zero, clock, reset, rsp.valid && (rsp.outcome != wmvs_pkg::OUTCOME_LABEL), rsp.winning_label == '0)
   // A vote count never exceeds the window length.
   `WMVS_ASSERT_SAME(a_count_range, clock, reset, rsp.valid, rsp.winning_count <= wmvs_pkg::COUNT_W'(wmvs_pkg::WINDOW_LEN))

endmodule

`default_nettype wire

[hdl/wmvs_datapath.sv]
// ----------------------------------------------------------------------------
// Window majority vote smoother: datapath
// Decision window shift line, per-class match counter, running best class
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmvs_datapath (
   input  wire                            clock,
   input  wire                            reset,
   input  wire wmvs_pkg::dp_cmd_type      cmd,
   input  wire [wmvs_pkg::KIND_W-1:0]     reading_kind,
   input  wire [wmvs_pkg::LABEL_W-1:0]    reading_label,
   input  wire [wmvs_pkg::THR_W-1:0]      vote_threshold,
   output logic [wmvs_pkg::OUT_W-1:0]     outcome,
   output logic [wmvs_pkg::LABEL_W-1:0]   winning_label,
   output logic [wmvs_pkg::COUNT_W-1:0]   winning_count
);

   wmvs_pkg::class_type window_ff [wmvs_pkg::WINDOW_LEN];
   wmvs_pkg::class_type top_class_ff;
   wmvs_pkg::count_type best_count_ff;
   wmvs_pkg::class_type top_class_in;
   wmvs_pkg::count_type best_count_in;
   wmvs_pkg::count_type match_count;

   logic [wmvs_pkg::OUT_W-1:0]   outcome_ff,   outcome_in;
   logic [wmvs_pkg::LABEL_W-1:0] label_ff,     label_in;
   logic [wmvs_pkg::COUNT_W-1:0] count_ff;

   // Number of window entries that hold the class under scan.
   always_comb begin
      match_count = '0;
      for (int i = 0; i < wmvs_pkg::WINDOW_LEN; i++) begin
         match_count = match_count +
                       wmvs_pkg::COUNT_W'(window_ff[i] == cmd.scan_class);
      end
   end

   // Strict greater-than keeps the earliest class on a tie.
   always_comb begin
      top_class_in  = top_class_ff;
      best_count_in = best_count_ff;
      if (cmd.load_item) begin
         top_class_in  = '0;
         best_count_in = '0;
      end else if (cmd.scan && (match_count > best_count_ff)) begin
         top_class_in  = cmd.scan_class;
         best_count_in = match_count;
      end
   end

   always_comb begin
      outcome_in = wmvs_pkg::OUTCOME_UNCERTAIN;
      label_in   = '0;
      if (best_count_ff > wmvs_pkg::COUNT_W'(vote_threshold)) begin
         if (top_class_ff == wmvs_pkg::CLASS_ANOMALY) begin
            outcome_in = wmvs_pkg::OUTCOME_ANOMALY;
         end else if (top_class_ff != wmvs_pkg::CLASS_UNCERTAIN) begin
            outcome_in = wmvs_pkg::OUTCOME_LABEL;
            label_in   = top_class_ff[wmvs_pkg::LABEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wmvs_pkg::WINDOW_LEN; i++) begin
            window_ff[i] <= wmvs_pkg::CLASS_UNCERTAIN;
         end
      end else if (cmd.load_item) begin
         for (int i = 0; i < wmvs_pkg::WINDOW_LEN - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[wmvs_pkg::WINDOW_LEN-1] <=
            wmvs_pkg::classify(reading_kind, reading_label);
      end
   end

   always_ff @(posedge clock) begin
      top_class_ff  <= top_class_in;
      best_count_ff <= best_count_in;
      if (cmd.load_out) begin
         outcome_ff <= outcome_in;
         label_ff   <= label_in;
         count_ff   <= best_count_ff;
      end
   end

   assign outcome       = outcome_ff;
   assign winning_label = label_ff;
   assign winning_count = count_ff;

endmodule

`default_nettype wire

[hdl/wmvs_ctrl.sv]
// ----------------------------------------------------------------------------
// Window majority vote smoother: controller
// Sequences one decision through the window shift, the class scan and the
// result register, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wmvs_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output wmvs_pkg::dp_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]          state_ff, state_in;
   wmvs_pkg::class_type class_ff, class_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_free;

   // The result register may be reloaded once its last result is taken.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      class_in       = class_ff;
      cmd.load_item  = 1'b0;
      cmd.scan       = 1'b0;
      cmd.scan_class = class_ff;
      cmd.load_out   = 1'b0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // No transfer is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_item = 1'b1;
               class_in      = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            class_in = class_ff + 1'b1;
            if (class_ff == wmvs_pkg::CLASS_LAST) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         class_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         class_ff     <= class_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire
